/* rtl/text_display_controller_assert.svh */
// Assertion macros shared by the display controller RTL.
`ifndef TEXT_DISPLAY_CONTROLLER_ASSERT_SVH
`define TEXT_DISPLAY_CONTROLLER_ASSERT_SVH

// cond and expr hold in the same cycle
`define TDC_ASSERT_SAME_CYCLE(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("tdc check failed: same-cycle implication");

// cond in one cycle, expr in the next
`define TDC_ASSERT_NEXT_CYCLE(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("tdc check failed: next-cycle implication");

`endif

/* rtl/tdc_pkg.sv */
package tdc_pkg;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] port_byte;
      logic [9:0] ram_address;
      logic [7:0] ram_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [9:0] cursor_now;
      logic [3:0] top_row_now;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_MOD,
      ST_EXEC,
      ST_ADV,
      ST_ROLL,
      ST_SETUP,
      ST_WALK,
      ST_READ,
      ST_RESP
   } state_type;

   localparam logic [1:0] OP_PORT_WRITE = 2'd0;
   localparam logic [1:0] OP_RAM_READ   = 2'd1;
   localparam logic [1:0] OP_RAM_WRITE  = 2'd2;

   localparam logic [6:0] CODE_NUL         = 7'h00;
   localparam logic [6:0] CODE_EOT         = 7'h04;
   localparam logic [6:0] CODE_BACKSPACE   = 7'h08;
   localparam logic [6:0] CODE_RIGHT       = 7'h09;
   localparam logic [6:0] CODE_LINE_FEED   = 7'h0A;
   localparam logic [6:0] CODE_UP          = 7'h0B;
   localparam logic [6:0] CODE_CLEAR       = 7'h0C;
   localparam logic [6:0] CODE_RETURN      = 7'h0D;
   localparam logic [6:0] CODE_ROLL        = 7'h1B;
   localparam logic [6:0] CODE_HOME        = 7'h1C;
   localparam logic [6:0] CODE_RETURN_KEEP = 7'h1D;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam int STROBE_BIT = 7;

endpackage

/* rtl/tdc_ram.sv */
module tdc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/text_display_controller.sv */
// Text display controller: COLUMNS x ROWS character screen over a video RAM.
// Input channel: present req_item with start high; it is taken on a clock edge
// where busy is low. operation selects a control-port write, a RAM read or a
// RAM write. Every transaction returns exactly one result: rsp_strobe is high
// for one cycle with rsp_item (RAM byte at the address, cursor, top row).
// The receiver cannot stall; the result must be taken in that cycle.
// Sequence: k address reduction steps first (k = ram_address/(COLUMNS*ROWS),
// rounded down; always zero at or above 1024 cells), then execute, RAM read
// and strobe for reads, writes and simple cursor codes. A stored character
// also passes through ST_ADV, a roll code through ST_ROLL. A roll with
// a row clear (line feed from the last row, or a character past the last
// cell) adds a setup step and the clear of one row, carriage return clears
// from the cursor column to the row end, and clear screen clears all cells:
// the single RAM write port clears one cell per cycle, stepped by one shared
// add/wrap unit. busy stays high until the cycle after the strobe, so a new
// transaction is accepted only after the previous result has been given.
// After reset busy is high while all COLUMNS*ROWS video RAM cells (1024 by
// default) are filled with spaces; cursor, top row and last byte are zero.
`include "text_display_controller_assert.svh"

module text_display_controller #(
   parameter int unsigned COLUMNS = 64,
   parameter int unsigned ROWS    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  tdc_pkg::req_type  req_item,
   output logic              busy,
   output logic              rsp_strobe,
   output tdc_pkg::rsp_type  rsp_item
);

   localparam int unsigned SCREEN = COLUMNS * ROWS;
   localparam int AW   = $clog2(SCREEN);
   localparam int CLW  = $clog2(COLUMNS);
   localparam int RW   = $clog2(ROWS);
   localparam int CNTW = $clog2(SCREEN + 1);
   localparam int AXW  = (AW > 10) ? AW : 10;

   localparam logic [AW:0]      SCREEN_W     = (AW+1)'(SCREEN);
   localparam logic [AW:0]      COL_STEP     = (AW+1)'(COLUMNS);
   localparam logic [AW:0]      BACK_ONE     = (AW+1)'(SCREEN - 1);
   localparam logic [AW:0]      UP_ONE       = (AW+1)'(SCREEN - COLUMNS);
   localparam logic [AW:0]      ONE_STEP     = (AW+1)'(1);
   localparam logic [AW-1:0]    LAST_POS     = AW'(SCREEN - 1);
   localparam logic [AW-1:0]    LAST_ROW_POS = AW'(SCREEN - COLUMNS);
   localparam logic [CLW-1:0]   LAST_COL     = CLW'(COLUMNS - 1);
   localparam logic [RW-1:0]    LAST_ROW     = RW'(ROWS - 1);
   localparam logic [CNTW-1:0]  FULL_COUNT   = CNTW'(SCREEN);
   localparam logic [CNTW-1:0]  ROW_COUNT    = CNTW'(COLUMNS);
   localparam logic [CNTW-1:0]  COUNT_ONE    = CNTW'(1);
   localparam logic [AXW:0]     SCREEN_X     = (AXW+1)'(SCREEN);
   localparam logic [AXW-1:0]   SCREEN_SUB   = AXW'(SCREEN);

   tdc_pkg::state_type state_ff, state_in;
   tdc_pkg::req_type   item_ff, item_in;
   logic [AXW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]      cursor_ff, cursor_in;
   logic [CLW-1:0]     col_ff, col_in;
   logic [RW-1:0]      top_ff, top_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [7:0]         last_byte_ff, last_byte_in;
   logic [AW-1:0]      walk_ptr_ff, walk_ptr_in;
   logic [CNTW-1:0]    walk_cnt_ff, walk_cnt_in;
   logic               roll_clear_ff, roll_clear_in;

   // shared add / wrap-at-screen unit
   logic [AW:0]   unit_a, unit_b, unit_sum;
   logic          unit_carry;
   logic [AW-1:0] unit_out;

   logic [6:0]    code;
   logic          port_act;
   logic          addr_big;
   logic [CLW-1:0] col_next;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata, ram_rdata;

   // decode of the latched transaction
   always_comb begin
      code     = item_ff.port_byte[6:0];
      port_act = (item_ff.operation == tdc_pkg::OP_PORT_WRITE) &&
                 (item_ff.port_byte != last_byte_ff) &&
                 item_ff.port_byte[tdc_pkg::STROBE_BIT];
      addr_big = {1'b0, addr_ff} >= SCREEN_X;
      col_next = (col_ff == LAST_COL) ? '0 : col_ff + CLW'(1);
   end

   always_comb begin
      unit_a = {1'b0, cursor_ff};
      unit_b = '0;
      case (state_ff)
         tdc_pkg::ST_EXEC: begin
            case (code)
               tdc_pkg::CODE_BACKSPACE: unit_b = BACK_ONE;
               tdc_pkg::CODE_RIGHT:     unit_b = ONE_STEP;
               tdc_pkg::CODE_LINE_FEED: unit_b = COL_STEP;
               tdc_pkg::CODE_UP,
               tdc_pkg::CODE_ROLL:      unit_b = UP_ONE;
               default: begin
                  // physical address of the cursor cell
                  unit_a = {1'b0, base_ff};
                  unit_b = {1'b0, cursor_ff};
               end
            endcase
         end
         tdc_pkg::ST_ADV: begin
            unit_b = ONE_STEP;
         end
         tdc_pkg::ST_ROLL: begin
            unit_a = {1'b0, base_ff};
            unit_b = COL_STEP;
         end
         tdc_pkg::ST_SETUP: begin
            unit_a = {1'b0, base_ff};
            unit_b = {1'b0, cursor_ff};
         end
         tdc_pkg::ST_INIT,
         tdc_pkg::ST_WALK: begin
            unit_a = {1'b0, walk_ptr_ff};
            unit_b = ONE_STEP;
         end
         default: begin
            unit_b = '0;
         end
      endcase
      unit_sum   = unit_a + unit_b;
      unit_carry = unit_sum >= SCREEN_W;
      unit_out   = unit_carry ? AW'(unit_sum - SCREEN_W) : AW'(unit_sum);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdc_pkg::ST_INIT: begin
            if (walk_cnt_ff == COUNT_ONE) state_in = tdc_pkg::ST_IDLE;
         end
         tdc_pkg::ST_IDLE: begin
            if (start) state_in = tdc_pkg::ST_MOD;
         end
         tdc_pkg::ST_MOD: begin
            if (!addr_big) state_in = tdc_pkg::ST_EXEC;
         end
         tdc_pkg::ST_EXEC: begin
            state_in = tdc_pkg::ST_READ;
            if (port_act) begin
               case (code)
                  tdc_pkg::CODE_LINE_FEED: begin
                     if (unit_carry) state_in = tdc_pkg::ST_ROLL;
                  end
                  tdc_pkg::CODE_CLEAR: state_in = tdc_pkg::ST_WALK;
                  tdc_pkg::CODE_RETURN: begin
                     if (col_ff != '0) state_in = tdc_pkg::ST_WALK;
                  end
                  tdc_pkg::CODE_ROLL: state_in = tdc_pkg::ST_ROLL;
                  tdc_pkg::CODE_NUL,
                  tdc_pkg::CODE_EOT,
                  tdc_pkg::CODE_BACKSPACE,
                  tdc_pkg::CODE_RIGHT,
                  tdc_pkg::CODE_UP,
                  tdc_pkg::CODE_HOME,
                  tdc_pkg::CODE_RETURN_KEEP: state_in = tdc_pkg::ST_READ;
                  default: state_in = tdc_pkg::ST_ADV;
               endcase
            end
         end
         tdc_pkg::ST_ADV: begin
            state_in = unit_carry ? tdc_pkg::ST_ROLL : tdc_pkg::ST_READ;
         end
         tdc_pkg::ST_ROLL: begin
            state_in = roll_clear_ff ? tdc_pkg::ST_SETUP : tdc_pkg::ST_READ;
         end
         tdc_pkg::ST_SETUP: state_in = tdc_pkg::ST_WALK;
         tdc_pkg::ST_WALK: begin
            if (walk_cnt_ff == COUNT_ONE) state_in = tdc_pkg::ST_READ;
         end
         tdc_pkg::ST_READ: state_in = tdc_pkg::ST_RESP;
         tdc_pkg::ST_RESP: state_in = tdc_pkg::ST_IDLE;
         default: state_in = tdc_pkg::ST_IDLE;
      endcase
   end

   // datapath updates and RAM port
   always_comb begin
      item_in       = item_ff;
      addr_in       = addr_ff;
      cursor_in     = cursor_ff;
      col_in        = col_ff;
      top_in        = top_ff;
      base_in       = base_ff;
      last_byte_in  = last_byte_ff;
      walk_ptr_in   = walk_ptr_ff;
      walk_cnt_in   = walk_cnt_ff;
      roll_clear_in = roll_clear_ff;
      ram_we        = 1'b0;
      ram_waddr     = walk_ptr_ff;
      ram_wdata     = tdc_pkg::SPACE_CHAR;
      case (state_ff)
         tdc_pkg::ST_INIT,
         tdc_pkg::ST_WALK: begin
            ram_we      = 1'b1;
            walk_ptr_in = unit_out;
            walk_cnt_in = walk_cnt_ff - COUNT_ONE;
         end
         tdc_pkg::ST_IDLE: begin
            if (start) begin
               item_in = req_item;
               addr_in = AXW'(req_item.ram_address);
            end
         end
         tdc_pkg::ST_MOD: begin
            if (addr_big) addr_in = addr_ff - SCREEN_SUB;
         end
         tdc_pkg::ST_EXEC: begin
            if (item_ff.operation == tdc_pkg::OP_RAM_WRITE) begin
               ram_we    = 1'b1;
               ram_waddr = AW'(addr_ff);
               ram_wdata = item_ff.ram_data;
            end
            if (item_ff.operation == tdc_pkg::OP_PORT_WRITE) begin
               last_byte_in = item_ff.port_byte;
            end
            if (port_act) begin
               case (code)
                  tdc_pkg::CODE_NUL,
                  tdc_pkg::CODE_EOT: begin
                     cursor_in = cursor_ff;
                  end
                  tdc_pkg::CODE_BACKSPACE: begin
                     cursor_in = unit_out;
                     col_in    = (col_ff == '0) ? LAST_COL : col_ff - CLW'(1);
                  end
                  tdc_pkg::CODE_RIGHT: begin
                     cursor_in = unit_out;
                     col_in    = col_next;
                  end
                  tdc_pkg::CODE_LINE_FEED: begin
                     // from the last row the cursor stays and the screen rolls
                     if (unit_carry) roll_clear_in = 1'b1;
                     else cursor_in = unit_out;
                  end
                  tdc_pkg::CODE_UP: begin
                     cursor_in = unit_out;
                  end
                  tdc_pkg::CODE_CLEAR: begin
                     cursor_in   = '0;
                     col_in      = '0;
                     top_in      = '0;
                     base_in     = '0;
                     walk_ptr_in = '0;
                     walk_cnt_in = FULL_COUNT;
                  end
                  tdc_pkg::CODE_RETURN: begin
                     if (col_ff != '0) begin
                        walk_ptr_in = unit_out;
                        walk_cnt_in = ROW_COUNT - CNTW'(col_ff);
                        cursor_in   = cursor_ff - AW'(col_ff);
                        col_in      = '0;
                     end
                  end
                  tdc_pkg::CODE_ROLL: begin
                     cursor_in     = unit_out;
                     roll_clear_in = 1'b0;
                  end
                  tdc_pkg::CODE_HOME: begin
                     cursor_in = '0;
                     col_in    = '0;
                  end
                  tdc_pkg::CODE_RETURN_KEEP: begin
                     cursor_in = cursor_ff - AW'(col_ff);
                     col_in    = '0;
                  end
                  default: begin
                     ram_we    = 1'b1;
                     ram_waddr = unit_out;
                     ram_wdata = {1'b0, code};
                  end
               endcase
            end
         end
         tdc_pkg::ST_ADV: begin
            if (unit_carry) begin
               cursor_in     = LAST_ROW_POS;
               col_in        = '0;
               roll_clear_in = 1'b1;
            end else begin
               cursor_in = unit_out;
               col_in    = col_next;
            end
         end
         tdc_pkg::ST_ROLL: begin
            base_in = unit_out;
            top_in  = (top_ff == LAST_ROW) ? '0 : top_ff + RW'(1);
         end
         tdc_pkg::ST_SETUP: begin
            walk_ptr_in = unit_out;
            walk_cnt_in = ROW_COUNT;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy                 = state_ff != tdc_pkg::ST_IDLE;
      ram_re               = state_ff == tdc_pkg::ST_READ;
      rsp_strobe           = state_ff == tdc_pkg::ST_RESP;
      rsp_item.read_data   = ram_rdata;
      rsp_item.cursor_now  = 10'(cursor_ff);
      rsp_item.top_row_now = 4'(top_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tdc_pkg::ST_INIT;
         cursor_ff     <= '0;
         col_ff        <= '0;
         top_ff        <= '0;
         base_ff       <= '0;
         last_byte_ff  <= '0;
         walk_ptr_ff   <= '0;
         walk_cnt_ff   <= FULL_COUNT;
         roll_clear_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         col_ff        <= col_in;
         top_ff        <= top_in;
         base_ff       <= base_in;
         last_byte_ff  <= last_byte_in;
         walk_ptr_ff   <= walk_ptr_in;
         walk_cnt_ff   <= walk_cnt_in;
         roll_clear_ff <= roll_clear_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      addr_ff <= addr_in;
   end

   tdc_ram #(
      .WIDTH (8),
      .DEPTH (SCREEN)
   ) u_video_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (AW'(addr_ff)),
      .rd_data (ram_rdata)
   );

   `TDC_ASSERT_NEXT_CYCLE(a_start_sets_busy, clock, reset, start && !busy, busy)
   `TDC_ASSERT_NEXT_CYCLE(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe && !busy)
   `TDC_ASSERT_SAME_CYCLE(a_cursor_on_screen, clock, reset, 1'b1, (cursor_ff <= LAST_POS) && (col_ff <= LAST_COL))
   `TDC_ASSERT_SAME_CYCLE(a_walk_count_live, clock, reset, (state_ff == tdc_pkg::ST_WALK) || (state_ff == tdc_pkg::ST_INIT), walk_cnt_ff != '0)

endmodule
